>>> rtl/core/column_prune_selector_unit_assert.svh
`ifndef COLUMN_PRUNE_SELECTOR_UNIT_ASSERT_SVH
`define COLUMN_PRUNE_SELECTOR_UNIT_ASSERT_SVH

// Same-cycle implication checked on every clock edge outside reset.
`define CPS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked on every clock edge outside reset.
`define CPS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/core/cps_pkg.sv
`timescale 1ns / 1ps

package cps_pkg;

  localparam int NumCols  = 256;
  localparam int MaxPerStep = 8;
  localparam int SumW     = 37;
  localparam int ScoreW   = 40;

  localparam logic [2:0] REG_DIFF_MODE  = 3'd0;
  localparam logic [2:0] REG_DECAY_EN   = 3'd1;
  localparam logic [2:0] REG_DECAY_RATE = 3'd2;
  localparam logic [2:0] REG_PER_STEP   = 3'd3;
  localparam logic [2:0] REG_LIMIT      = 3'd4;
  localparam logic [2:0] REG_INTERVAL   = 3'd5;
  localparam logic [2:0] REG_ACTIVE     = 3'd6;

  typedef struct packed {
    logic              pruned;
    logic [ScoreW-1:0] score;
  } col_entry_t;

  typedef struct packed {
    logic done;
    logic zero;
  } rem_status_t;

endpackage

>>> rtl/core/cps_rem.sv
`timescale 1ns / 1ps

module cps_rem (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [30:0]          dividend,
  input  logic [15:0]          divisor,
  output cps_pkg::rem_status_t status
);

  logic [30:0] dvd;
  logic [15:0] dsr;
  logic [15:0] rem;
  logic [4:0]  cnt;
  logic        run;
  logic        done;
  logic [16:0] trial;

  assign trial = {rem, dvd[30]};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= 5'd31;
      end else if (run) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
    end else if (run) begin
      dvd <= {dvd[29:0], 1'b0};
      if (trial >= {1'b0, dsr}) begin
        rem <= 16'(trial - {1'b0, dsr});
      end else begin
        rem <= trial[15:0];
      end
    end
  end

  assign status.done = done;
  assign status.zero = (rem == 16'd0);

endmodule

>>> rtl/core/column_prune_selector_unit.sv
`timescale 1ns / 1ps

// Column prune selector. One item is handled at a time. After reset a clearing pass over
// all 256 entries zeroes the score memory before the first item is taken. A weight element
// is added into the column sum; when it ends a column, the score is read from memory, and
// when that score is updated the split 40x16 decay multiply and the write back follow. A
// step item first runs the (step-1) modulo interval check (a 31-bit serial remainder), then
// for each pruned column one scan over the score memory (active_cols taken as at most 256),
// after which its index waits to be taken at the output; while a result waits, no item is
// taken.
module column_prune_selector_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // weight[15:0], grad[31:16], col[39:32], step[70:40]
  input  logic        s_tuser,   // kind
  input  logic        s_tlast,   // col_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // pruned_col[7:0]
  output logic        m_tlast,   // last
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_ELEM  = 3'd2;
  localparam logic [2:0] S_UPD1  = 3'd3;
  localparam logic [2:0] S_UPD2  = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_SCAN  = 3'd6;
  localparam logic [2:0] S_EMIT  = 3'd7;

  logic        diff_mode;
  logic        decay_enable;
  logic [15:0] decay_rate;
  logic [3:0]  prune_per_step;
  logic [8:0]  prune_limit;
  logic [15:0] step_period;
  logic [8:0]  active_cols;

  logic [2:0]  state;
  logic [15:0] weight_r;
  logic [15:0] grad_r;
  logic [7:0]  col_r;
  logic        col_end_r;
  logic [36:0] column_sum;
  logic [8:0]  pruned_count;

  cps_pkg::col_entry_t mem [cps_pkg::NumCols];
  cps_pkg::col_entry_t rd_data;
  logic [7:0]  rd_addr;
  logic        wr_en;
  logic [7:0]  wr_addr;
  cps_pkg::col_entry_t wr_data;

  logic [8:0]  clr_cnt;
  logic [35:0] prod_hi;
  logic [35:0] prod_lo;

  logic [8:0]  scan_j;
  logic        cmp_valid;
  logic [7:0]  cmp_idx;
  logic        found;
  logic [7:0]  best;
  logic [39:0] best_score;
  logic [8:0]  cand;
  logic [3:0]  round;

  logic        accept;
  logic        rem_start;
  cps_pkg::rem_status_t rem_st;
  logic [15:0] interval_eff;
  logic [3:0]  k_eff;
  logic [8:0]  ncols;
  logic [16:0] mag_w;
  logic [16:0] mag_g;
  logic [33:0] elem_prod;
  logic [36:0] elem_add;
  logic [37:0] sum_raw;
  logic [36:0] sum_next;
  logic [55:0] decay_full;
  logic [40:0] score_raw;
  logic [39:0] score_next;
  logic        scan_done;
  logic        is_last;

  assign accept       = s_tvalid && s_tready;
  assign s_tready     = (state == S_IDLE);
  assign rem_start    = accept && s_tuser;
  assign interval_eff = (step_period == 16'd0) ? 16'd1 : step_period;
  assign k_eff        = (prune_per_step > 4'd8) ? 4'd8 : prune_per_step;
  assign ncols        = (active_cols > 9'd256) ? 9'd256 : active_cols;

  cps_rem u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (rem_start),
    .dividend (31'(s_tdata[70:40] - 31'd1)),
    .divisor  (interval_eff),
    .status   (rem_st)
  );

  always_comb begin
    mag_w     = weight_r[15] ? 17'(17'h10000 - {1'b0, weight_r}) : {1'b0, weight_r};
    mag_g     = grad_r[15] ? 17'(17'h10000 - {1'b0, grad_r}) : {1'b0, grad_r};
    elem_prod = 34'(mag_w * mag_g);
    elem_add  = diff_mode ? 37'(elem_prod) : 37'(mag_w);
    sum_raw   = {1'b0, column_sum} + {1'b0, elem_add};
    sum_next  = sum_raw[37] ? {37{1'b1}} : sum_raw[36:0];
    decay_full = {prod_hi, 20'd0} + 56'(prod_lo);
    score_raw = {1'b0, decay_full[55:16]} + 41'(column_sum);
    score_next = score_raw[40] ? {40{1'b1}} : score_raw[39:0];
    scan_done = (scan_j >= ncols) && !cmp_valid;
    is_last   = (round == 4'(k_eff - 4'd1)) || (cand == 9'd1);
  end

  always_comb begin
    rd_addr = col_r;
    wr_en   = 1'b0;
    wr_addr = best;
    wr_data = '{pruned: 1'b1, score: best_score};
    unique case (state)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_cnt[7:0];
        wr_data = '0;
      end
      S_UPD2: begin
        wr_en   = 1'b1;
        wr_addr = col_r;
        wr_data = '{pruned: 1'b0, score: score_next};
      end
      S_SCAN: begin
        rd_addr = scan_j[7:0];
        wr_en   = scan_done && found;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      diff_mode      <= 1'b0;
      decay_enable   <= 1'b1;
      decay_rate     <= 16'hFFFF;
      prune_per_step <= 4'd1;
      prune_limit    <= 9'd0;
      step_period    <= 16'd1;
      active_cols    <= 9'd256;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        cps_pkg::REG_DIFF_MODE:  diff_mode      <= cfg_wdata[0];
        cps_pkg::REG_DECAY_EN:   decay_enable   <= cfg_wdata[0];
        cps_pkg::REG_DECAY_RATE: decay_rate     <= cfg_wdata;
        cps_pkg::REG_PER_STEP:   prune_per_step <= cfg_wdata[3:0];
        cps_pkg::REG_LIMIT:      prune_limit    <= cfg_wdata[8:0];
        cps_pkg::REG_INTERVAL:   step_period    <= cfg_wdata;
        cps_pkg::REG_ACTIVE:     active_cols    <= cfg_wdata[8:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      weight_r  <= s_tdata[15:0];
      grad_r    <= s_tdata[31:16];
      col_r     <= s_tdata[39:32];
      col_end_r <= s_tlast;
    end
    if (state == S_UPD1) begin
      prod_hi <= 36'(rd_data.score[39:20] * decay_rate);
      prod_lo <= 36'(rd_data.score[19:0] * decay_rate);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_cnt      <= '0;
      column_sum   <= '0;
      pruned_count <= '0;
      m_tvalid     <= 1'b0;
      m_tdata      <= '0;
      m_tlast      <= 1'b0;
      scan_j       <= '0;
      cmp_valid    <= 1'b0;
      cmp_idx      <= '0;
      found        <= 1'b0;
      best         <= '0;
      best_score   <= '0;
      cand         <= '0;
      round        <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 9'd1;
          if (clr_cnt == 9'(cps_pkg::NumCols - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            state <= s_tuser ? S_DIV : S_ELEM;
          end
        end
        S_ELEM: begin
          if (!col_end_r) begin
            column_sum <= sum_next;
            state      <= S_IDLE;
          end else begin
            column_sum <= sum_next;
            state      <= S_UPD1;
          end
        end
        S_UPD1: begin
          if (decay_enable && (pruned_count < prune_limit) && !rd_data.pruned) begin
            state <= S_UPD2;
          end else begin
            column_sum <= '0;
            state      <= S_IDLE;
          end
        end
        S_UPD2: begin
          column_sum <= '0;
          state      <= S_IDLE;
        end
        S_DIV: begin
          if (rem_st.done) begin
            if ((pruned_count >= prune_limit) || !rem_st.zero || (k_eff == 4'd0)) begin
              state <= S_IDLE;
            end else begin
              round     <= '0;
              scan_j    <= '0;
              cmp_valid <= 1'b0;
              found     <= 1'b0;
              cand      <= '0;
              state     <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          cmp_valid <= (scan_j < ncols);
          cmp_idx   <= scan_j[7:0];
          if (scan_j < ncols) begin
            scan_j <= scan_j + 9'd1;
          end
          if (cmp_valid && !rd_data.pruned) begin
            cand <= cand + 9'd1;
            if (!found || (rd_data.score < best_score)) begin
              found      <= 1'b1;
              best       <= cmp_idx;
              best_score <= rd_data.score;
            end
          end
          if (scan_done) begin
            if (!found) begin
              state <= S_IDLE;
            end else begin
              if (pruned_count != 9'h1FF) begin
                pruned_count <= pruned_count + 9'd1;
              end
              m_tvalid <= 1'b1;
              m_tdata  <= best;
              m_tlast  <= is_last;
              state    <= S_EMIT;
            end
          end
        end
        S_EMIT: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
            if (m_tlast) begin
              state <= S_IDLE;
            end else begin
              round     <= round + 4'd1;
              scan_j    <= '0;
              cmp_valid <= 1'b0;
              found     <= 1'b0;
              cand      <= '0;
              state     <= S_SCAN;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`include "column_prune_selector_unit_assert.svh"

  `CPS_ASSERT_NOW(a_no_accept_while_out, m_tvalid, !s_tready)
  `CPS_ASSERT_NOW(a_out_only_in_emit, m_tvalid, state == S_EMIT)
  `CPS_ASSERT_NOW(a_clear_blocks_input, state == S_CLEAR, !s_tready && !m_tvalid)
  `CPS_ASSERT_NEXT(a_count_monotonic, 1'b1, pruned_count >= $past(pruned_count))

endmodule

>>> tb/column_prune_selector_unit_tb.sv
`timescale 1ns / 1ps

module column_prune_selector_unit_tb;

  localparam int          LIMIT_CYCLES = 10000000;
  localparam int          SETTLE       = 2200;
  localparam logic [63:0] SUM_MAX      = (64'd1 << cps_pkg::SumW) - 64'd1;
  localparam logic [63:0] SCORE_MAX    = (64'd1 << cps_pkg::ScoreW) - 64'd1;
  localparam int          KIND_ELEM    = 0;
  localparam int          KIND_STEP    = 1;

  typedef struct packed {
    logic [7:0] col;
    logic       last;
  } prune_res_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [71:0] s_tdata;   // weight[15:0], grad[31:16], col[39:32], step[70:40]
  logic        s_tuser;   // kind
  logic        s_tlast;   // col_end
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;   // pruned_col[7:0]
  logic        m_tlast;   // last
  logic        cfg_we;
  logic [2:0]  cfg_addr;
  logic [15:0] cfg_wdata;

  column_prune_selector_unit i_dut (.*);

  // Shadow state of the selector.
  logic        m_diff;
  logic        m_decay_en;
  int unsigned m_rate;
  int unsigned m_per_step;
  int unsigned m_limit;
  int unsigned m_interval;
  int unsigned m_active;
  logic [63:0] col_sum;
  logic [63:0] scores [cps_pkg::NumCols];
  logic        pruned [cps_pkg::NumCols];
  int unsigned pruned_cnt;

  prune_res_t pending_prunes[$];
  int         mismatches;
  int         cycles;
  int         hold_cycles;
  logic       calm;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 30);
    end
  end

  always @(posedge clk) begin
    prune_res_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_prunes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result: col %0d last %0b", m_tdata, m_tlast);
      end else begin
        want = pending_prunes.pop_front();
        if (want.col !== m_tdata || want.last !== m_tlast) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected col %0d last %0b, got col %0d last %0b",
                     want.col, want.last, m_tdata, m_tlast);
        end
      end
    end
  end

  function automatic logic [63:0] magnitude(logic [15:0] v);
    int x;
    x = $signed(v);
    return (x < 0) ? 64'(-x) : 64'(x);
  endfunction

  function automatic void reset_shadow();
    m_diff = 1'b0;
    m_decay_en = 1'b1;
    m_rate = 65535;
    m_per_step = 1;
    m_limit = 0;
    m_interval = 1;
    m_active = 256;
    col_sum = '0;
    pruned_cnt = 0;
    for (int i = 0; i < cps_pkg::NumCols; i++) begin
      scores[i] = '0;
      pruned[i] = 1'b0;
    end
  endfunction

  function automatic void accumulate(logic [15:0] w, logic [15:0] g, logic [7:0] col,
                                     logic cend);
    logic [63:0] add;
    logic [63:0] s;
    add = m_diff ? magnitude(w) * magnitude(g) : magnitude(w);
    col_sum = col_sum + add;
    if (col_sum > SUM_MAX) col_sum = SUM_MAX;
    if (!cend) return;
    if (m_decay_en && pruned_cnt < m_limit && !pruned[col]) begin
      s = ((scores[col] * 64'(m_rate)) >> 16) + col_sum;
      if (s > SCORE_MAX) s = SCORE_MAX;
      scores[col] = s;
    end
    col_sum = '0;
  endfunction

  function automatic void select_prunes(logic [30:0] step);
    logic [30:0] phase;
    int unsigned ivl;
    int unsigned k;
    int unsigned ncols;
    int          best;
    prune_res_t  picks[$];
    prune_res_t  r;
    phase = step - 31'd1;
    ivl = (m_interval == 0) ? 1 : m_interval;
    k = (m_per_step > cps_pkg::MaxPerStep) ? cps_pkg::MaxPerStep : m_per_step;
    ncols = (m_active < cps_pkg::NumCols) ? m_active : cps_pkg::NumCols;
    if (pruned_cnt >= m_limit || (32'(phase) % ivl) != 0) return;
    for (int i = 0; i < k; i++) begin
      best = -1;
      for (int j = 0; j < ncols; j++) begin
        if (!pruned[j] && (best < 0 || scores[j] < scores[best])) best = j;
      end
      if (best < 0) break;
      pruned[best] = 1'b1;
      if (pruned_cnt < 511) pruned_cnt++;
      r.col = best[7:0];
      r.last = 1'b0;
      picks.insert(picks.size(), r);
    end
    if (picks.size() > 0) picks[picks.size() - 1].last = 1'b1;
    foreach (picks[i]) pending_prunes.insert(pending_prunes.size(), picks[i]);
  endfunction

  task automatic send_item(int kind, logic [15:0] w, logic [15:0] g, logic [7:0] col,
                           logic cend, logic [30:0] step);
    int gap;
    if (!calm && $urandom_range(0, 99) < 30) begin
      gap = $urandom_range(1, 4);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind[0];
    s_tlast <= cend;
    s_tdata <= {1'b0, step, col, g, w};
    do @(posedge clk); while (!s_tready);
    if (kind == KIND_STEP) select_prunes(step);
    else accumulate(w, g, col, cend);
  endtask

  task automatic send_step(logic [30:0] step);
    send_item(KIND_STEP, '0, '0, '0, 1'b0, step);
  endtask

  task automatic send_column(logic [7:0] col, int n);
    for (int i = 0; i < n; i++)
      send_item(KIND_ELEM, 16'($urandom), 16'($urandom), col, i == n - 1, 31'($urandom));
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_prunes.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] addr, int unsigned value);
    s_tvalid <= 1'b0;
    do @(posedge clk); while (!s_tready);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= value[15:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (addr)
      cps_pkg::REG_DIFF_MODE:  m_diff = value[0];
      cps_pkg::REG_DECAY_EN:   m_decay_en = value[0];
      cps_pkg::REG_DECAY_RATE: m_rate = value & 16'hFFFF;
      cps_pkg::REG_PER_STEP:   m_per_step = value & 4'hF;
      cps_pkg::REG_LIMIT:      m_limit = value & 9'h1FF;
      cps_pkg::REG_INTERVAL:   m_interval = value & 16'hFFFF;
      cps_pkg::REG_ACTIVE:     m_active = value & 9'h1FF;
      default: ;
    endcase
  endtask

  task automatic test_reset_state();
    send_column(8'd2, 3);
    send_step(31'd1);
    send_step(31'd2);
    drain();
  endtask

  task automatic test_extremes();
    write_reg(cps_pkg::REG_LIMIT, 256);
    write_reg(cps_pkg::REG_ACTIVE, 8);
    write_reg(cps_pkg::REG_PER_STEP, 2);
    send_item(KIND_ELEM, 16'h8000, 16'h7FFF, 8'd0, 1'b0, 31'h7FFFFFFF);
    send_item(KIND_ELEM, 16'h7FFF, 16'h8000, 8'd0, 1'b1, 31'd0);
    send_item(KIND_ELEM, 16'h0000, 16'h0000, 8'd1, 1'b1, 31'd0);
    send_item(KIND_ELEM, 16'hFFFF, 16'hFFFF, 8'd255, 1'b1, 31'd0);
    send_step(31'd0);
    send_step(31'h7FFFFFFF);
    send_step(31'd1);
    drain();
    write_reg(cps_pkg::REG_DIFF_MODE, 1);
    write_reg(cps_pkg::REG_DECAY_RATE, 0);
    for (int i = 0; i < 130; i++)
      send_item(KIND_ELEM, 16'h8000, 16'h8000, 8'd3, i == 129, '0);
    send_item(KIND_ELEM, 16'h8000, 16'h8000, 8'd4, 1'b1, '0);
    write_reg(cps_pkg::REG_PER_STEP, 0);
    send_step(31'd5);
    drain();
    write_reg(cps_pkg::REG_PER_STEP, 15);
    write_reg(cps_pkg::REG_INTERVAL, 0);
    send_step(31'd7);
    drain();
    write_reg(cps_pkg::REG_INTERVAL, 65535);
    write_reg(cps_pkg::REG_ACTIVE, 0);
    send_step(31'd1);
    drain();
    write_reg(cps_pkg::REG_ACTIVE, 300);
    write_reg(cps_pkg::REG_DECAY_EN, 0);
    send_column(8'd200, 2);
    send_step(31'd65536);
    send_step(31'd65537);
    drain();
  endtask

  task automatic test_output_stall();
    write_reg(cps_pkg::REG_DECAY_EN, 1);
    write_reg(cps_pkg::REG_DECAY_RATE, 65535);
    write_reg(cps_pkg::REG_DIFF_MODE, 0);
    write_reg(cps_pkg::REG_INTERVAL, 1);
    write_reg(cps_pkg::REG_PER_STEP, 8);
    write_reg(cps_pkg::REG_ACTIVE, 64);
    @(posedge clk);
    hold_cycles = 3000;
    for (int i = 0; i < 4; i++) send_step(31'(i + 1));
    drain();
  endtask

  task automatic test_random();
    int n;
    for (int p = 0; p < 8; p++) begin
      calm = (p == 3);
      write_reg(cps_pkg::REG_DIFF_MODE, $urandom_range(0, 1));
      write_reg(cps_pkg::REG_DECAY_EN, $urandom_range(0, 5) != 0);
      write_reg(cps_pkg::REG_DECAY_RATE,
                (p == 1) ? 0 : (p == 2) ? 65535 : $urandom_range(0, 65535));
      write_reg(cps_pkg::REG_PER_STEP, $urandom_range(1, 3));
      write_reg(cps_pkg::REG_LIMIT, (pruned_cnt + $urandom_range(10, 30) > 256) ? 256
                                    : pruned_cnt + $urandom_range(10, 30));
      write_reg(cps_pkg::REG_INTERVAL, $urandom_range(1, 4));
      write_reg(cps_pkg::REG_ACTIVE, (p == 7) ? 256 : $urandom_range(16, 160));
      n = 0;
      while (n < 45) begin
        if ($urandom_range(0, 5) == 0) begin
          send_step(($urandom_range(0, 3) == 0) ? 31'($urandom) : 31'($urandom_range(0, 40)));
          n++;
        end else if ($urandom_range(0, 9) == 0) begin
          send_item(KIND_ELEM, 16'($urandom), 16'($urandom), 8'($urandom), $urandom_range(0, 1),
                    31'($urandom));
          n++;
        end else begin
          send_column(8'($urandom_range(0, m_active > 0 ? m_active - 1 : 0)),
                      $urandom_range(1, 5));
          n += 3;
        end
      end
      drain();
    end
    calm = 1'b0;
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    s_tlast = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    m_tready = 1'b0;
    mismatches = 0;
    cycles = 0;
    hold_cycles = 0;
    calm = 1'b0;
    reset_shadow();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    repeat (300) @(posedge clk);
    test_reset_state();
    test_extremes();
    test_output_stall();
    test_random();
    drain();
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/cps_pkg.sv
rtl/core/cps_rem.sv
rtl/core/column_prune_selector_unit.sv
tb/column_prune_selector_unit_tb.sv
